@@ hdl/sparse_matrix_transpose_assert.svh @@
// ----------------------------------------------------------------------------
// sparse_matrix_transpose_assert.svh
// Assertion macros used by the transpose checker.
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_TRANSPOSE_ASSERT_SVH
`define SPARSE_MATRIX_TRANSPOSE_ASSERT_SVH

// same-cycle implication
`define SMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/smt_pkg.sv @@
// ----------------------------------------------------------------------------
// smt_pkg
// Types and constants for the sparse matrix transpose.
// ----------------------------------------------------------------------------
`default_nettype none

package smt_pkg;

  localparam int IDX_W            = 6;
  localparam int VALUE_W          = 64;
  localparam int TDATA_W          = 80;
  localparam int DEF_MAX_ENTRIES  = 64;
  localparam int DEF_MAX_DIM      = 64;
  localparam int DEF_VALUE_BITS   = 64;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } key_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

@@ hdl/smt_cell.sv @@
// ----------------------------------------------------------------------------
// smt_cell
// One slot of the sorted chain: holds an entry, inserts by column, shifts out.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_cell import smt_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire  cell_ctrl_t      ctrl,
  input  wire  key_t            new_key,
  input  wire  [VALUE_BITS-1:0] new_value,
  input  wire  key_t            prev_key,
  input  wire  [VALUE_BITS-1:0] prev_value,
  input  wire                   prev_keep,
  input  wire  key_t            next_key,
  input  wire  [VALUE_BITS-1:0] next_value,
  output key_t                  key,
  output logic [VALUE_BITS-1:0] value,
  output logic                  keep
);

  // equal columns stay ahead: stable order
  assign keep = key.valid && (key.col <= new_key.col);

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (ctrl.ins) begin
      if (!keep) begin
        key <= prev_keep ? new_key : prev_key;
      end
    end else if (ctrl.shift) begin
      key <= next_key;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!keep) begin
        value <= prev_keep ? new_value : prev_value;
      end
    end else if (ctrl.shift) begin
      value <= next_value;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sparse_matrix_transpose.sv @@
// ----------------------------------------------------------------------------
// sparse_matrix_transpose
// Coordinate-form sparse transpose built on a sorted chain of entry cells.
// ----------------------------------------------------------------------------
// Entries are taken one per cycle while loading; each beat is inserted into a
// chain of MAX_ENTRIES cells kept sorted by column, equal columns in arrival
// order. The beat with tlast closes the matrix; input is then held off while
// the chain shifts out one transposed entry per cycle, while the receiver does
// not stall, through the output register. Entries out of range or beyond
// capacity are dropped and flagged in tuser on every beat of that run. A run
// that stores nothing gives no output beats.
`default_nettype none

module sparse_matrix_transpose import smt_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int MAX_DIM     = DEF_MAX_DIM,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                s_tvalid,
  output logic               s_tready,
  input  wire  [TDATA_W-1:0] s_tdata,   // in_row[5:0], in_col[11:6], in_value[75:12]
  input  wire                s_tlast,
  output logic               m_tvalid,
  input  wire                m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // out_row[5:0], out_col[11:6], out_value[75:12]
  output logic               m_tlast,
  output logic [0:0]         m_tuser    // overflow[0]
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  state_t          state, state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   remaining;
  logic            dropped;
  logic            run_ovf;

  logic            accept;
  logic            in_ok;
  logic            out_load;
  logic [CW-1:0]   count_upd;
  cell_ctrl_t      ctrl;
  key_t            new_key;
  logic [VALUE_BITS-1:0] new_value;

  key_t                  keys   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] values [MAX_ENTRIES];
  logic                  keeps  [MAX_ENTRIES];

  assign accept    = s_tvalid && s_tready;
  assign in_ok     = (32'(s_tdata[IDX_W-1:0]) < 32'(MAX_DIM))
                  && (32'(s_tdata[2*IDX_W-1:IDX_W]) < 32'(MAX_DIM))
                  && (count < CW'(MAX_ENTRIES));
  assign count_upd = count + CW'(in_ok);

  assign new_key.valid = 1'b1;
  assign new_key.row   = s_tdata[IDX_W-1:0];
  assign new_key.col   = s_tdata[2*IDX_W-1:IDX_W];
  assign new_value     = s_tdata[2*IDX_W +: VALUE_BITS];

  assign ctrl.ins   = accept && in_ok;
  assign ctrl.shift = out_load;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && s_tlast) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (remaining == '0) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
      end
      ST_DRAIN: begin
        out_load = (remaining != '0) && (!m_tvalid || m_tready);
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      remaining <= '0;
      dropped   <= 1'b0;
      run_ovf   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (s_tlast) begin
          remaining <= count_upd;
          run_ovf   <= dropped || !in_ok;
          count     <= '0;
          dropped   <= 1'b0;
        end else begin
          count   <= count_upd;
          dropped <= dropped || !in_ok;
        end
      end else if (out_load) begin
        remaining <= remaining - CW'(1);
      end
    end
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_chain
    key_t                  p_key, n_key;
    logic [VALUE_BITS-1:0] p_value, n_value;
    logic                  p_keep;

    if (i == 0) begin : g_head
      assign p_key   = '0;
      assign p_value = '0;
      assign p_keep  = 1'b1;
    end else begin : g_body
      assign p_key   = keys[i-1];
      assign p_value = values[i-1];
      assign p_keep  = keeps[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign n_key   = '0;
      assign n_value = '0;
    end else begin : g_mid
      assign n_key   = keys[i+1];
      assign n_value = values[i+1];
    end

    smt_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_key    (new_key),
      .new_value  (new_value),
      .prev_key   (p_key),
      .prev_value (p_value),
      .prev_keep  (p_keep),
      .next_key   (n_key),
      .next_value (n_value),
      .key        (keys[i]),
      .value      (values[i]),
      .keep       (keeps[i])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(TDATA_W - VALUE_W - 2*IDX_W)'(0), VALUE_W'(values[0]),
                  keys[0].row, keys[0].col};
      m_tlast <= (remaining == CW'(1));
      m_tuser <= run_ovf;
    end
  end

endmodule

`default_nettype wire

@@ hdl/smt_checker.sv @@
// ----------------------------------------------------------------------------
// smt_checker
// Port-level checks for the sparse matrix transpose.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_matrix_transpose_assert.svh"

module smt_checker import smt_pkg::*; (
  input wire               clk,
  input wire               rst,
  input wire               s_tvalid,
  input wire               s_tready,
  input wire [TDATA_W-1:0] s_tdata,
  input wire               s_tlast,
  input wire               m_tvalid,
  input wire               m_tready,
  input wire [TDATA_W-1:0] m_tdata,
  input wire               m_tlast,
  input wire [0:0]         m_tuser
);

  // input is closed once a matrix ends
  `SMT_ASSERT_NEXT(a_close_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "input open after last beat")
  // mid-run beats only while input is held off
  `SMT_ASSERT_NOW(a_no_load_mid_run, m_tvalid && !m_tlast, !s_tready, "input open during output run")
  // stalled beat holds
  `SMT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output beat changed under stall")

endmodule

bind sparse_matrix_transpose smt_checker u_smt_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sparse matrix transpose.
// ----------------------------------------------------------------------------
// Streams coordinate triplets into the block, one matrix per tlast, and keeps
// its own transpose of each matrix: entries bucketed by column with a prefix
// sum and scattered in arrival order. Every output beat is compared field by
// field with the oldest expected beat. A short directed set covers the index
// and value extremes, equal columns and single-entry matrices. Random matrices
// follow, some filling or overrunning the entry store. The sender pauses in
// bursts, the receiver stalls in segments, and once holds off for a long
// stretch.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smt_pkg::*;

  localparam int STALL_LIMIT    = 4000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int RANDOM_ITEMS   = 480;
  localparam int DRAIN_SLACK    = 2 * DEF_MAX_ENTRIES + 8;

  typedef struct packed {
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               overflow;
  } triplet_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_LIGHT, RX_HEAVY} rx_mode_t;

  class transpose_tracker;
    triplet_t    held[$];
    int unsigned col_count[DEF_MAX_DIM];
    bit          dropped;
    triplet_t    transposed_q[$];
    int          errors;
    int          matrices;
    int          overflow_runs;
    int          beats_checked;

    function void take_entry(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                             logic [VALUE_W-1:0] value, logic last);
      int unsigned place[DEF_MAX_DIM];
      triplet_t    scattered[DEF_MAX_ENTRIES];
      triplet_t    t;
      int unsigned sum;
      int          n;
      if (row >= DEF_MAX_DIM || col >= DEF_MAX_DIM || held.size() >= DEF_MAX_ENTRIES) begin
        dropped = 1'b1;
      end else begin
        t = '{row: row, col: col, value: value, last: 1'b0, overflow: 1'b0};
        held.push_back(t);
        col_count[col]++;
      end
      if (!last) return;
      sum = 0;
      for (int c = 0; c < DEF_MAX_DIM; c++) begin
        place[c] = sum;
        sum += col_count[c];
      end
      n = held.size();
      foreach (held[i]) begin
        t.row      = held[i].col;
        t.col      = held[i].row;
        t.value    = held[i].value;
        t.last     = 1'b0;
        t.overflow = 1'b0;
        scattered[place[held[i].col]] = t;
        place[held[i].col]++;
      end
      for (int i = 0; i < n; i++) begin
        t = scattered[i];
        t.last = (i == n - 1);
        t.overflow = dropped;
        transposed_q.push_back(t);
      end
      matrices++;
      if (dropped) overflow_runs++;
      held.delete();
      foreach (col_count[c]) col_count[c] = 0;
      dropped = 1'b0;
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_beat(triplet_t got);
      triplet_t want;
      if (transposed_q.size() == 0) begin
        $error("unexpected output beat: row %0d col %0d value 0x%0h",
               got.row, got.col, got.value);
        errors++;
        return;
      end
      want = transposed_q.pop_front();
      beats_checked++;
      compare_field("out_row", 64'(want.row), 64'(got.row));
      compare_field("out_col", 64'(want.col), 64'(got.col));
      compare_field("out_value", want.value, got.value);
      compare_field("out_last", 64'(want.last), 64'(got.last));
      compare_field("overflow", 64'(want.overflow), 64'(got.overflow));
    endfunction

    function int pending();
      return transposed_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tlast;
  logic [0:0]         m_tuser;

  transpose_tracker sb = new();
  int  items_in = 0;
  int  beats_out = 0;
  int  burst_left = 0;
  int  random_sent = 0;
  bit  holdoff_done = 1'b0;

  sparse_matrix_transpose uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // beats are taken on both sides at the rising edge
  always @(posedge clk) begin
    triplet_t got;
    if (!rst && s_tvalid && s_tready) begin
      sb.take_entry(s_tdata[5:0], s_tdata[11:6], s_tdata[75:12], s_tlast);
      items_in++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.row      = m_tdata[5:0];
      got.col      = m_tdata[11:6];
      got.value    = m_tdata[75:12];
      got.last     = m_tlast;
      got.overflow = m_tuser[0];
      sb.check_beat(got);
      beats_out++;
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("no beat accepted for %0d cycles, %0d output beats outstanding",
             STALL_LIMIT, sb.pending());
    $display("FAIL");
    $finish;
  end

  // receiver: segments of differing stall density, one long hold-off
  initial begin
    int       seg_left;
    rx_mode_t mode;
    seg_left = 0;
    mode = RX_STEADY;
    forever begin
      @(negedge clk);
      if (!holdoff_done && beats_out >= 150) begin
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_done = 1'b1;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 150);
        mode = rx_mode_t'($urandom_range(0, 3));
      end
      seg_left--;
      case (mode)
        RX_STEADY: m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
        default:   m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // called and returns at a falling edge
  task automatic send_entry(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                            input logic [VALUE_W-1:0] value, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      s_tdata  <= TDATA_W'({$urandom, $urandom, $urandom});
      s_tlast  <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 120)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, value, col, row};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return IDX_W'($urandom_range(0, DEF_MAX_DIM - 1));
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_matrix(input int n);
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] col;
    bit               narrow;
    narrow = ($urandom_range(0, 2) == 0);
    base = IDX_W'($urandom_range(0, DEF_MAX_DIM - 1));
    for (int i = 0; i < n; i++) begin
      col = narrow ? base + IDX_W'($urandom_range(0, 2)) : pick_index();
      send_entry(pick_index(), col, pick_value(), i == n - 1);
      random_sent++;
    end
  endtask

  initial begin
    int size;
    int k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single-entry matrices at both index extremes
    send_entry(6'd0, 6'd0, 64'h0, 1'b1);
    send_entry(6'd63, 6'd63, '1, 1'b1);
    // equal columns at both ends must keep arrival order
    send_entry(6'd5, 6'd63, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_entry(6'd1, 6'd0, 64'h5555_5555_5555_5555, 1'b0);
    send_entry(6'd63, 6'd63, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_entry(6'd0, 6'd0, 64'hFEDC_BA98_7654_3210, 1'b0);
    send_entry(6'd7, 6'd31, 64'h8000_0000_0000_0001, 1'b0);
    send_entry(6'd63, 6'd0, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1);
    // columns arriving in falling order
    send_entry(6'd0, 6'd40, 64'h1, 1'b0);
    send_entry(6'd1, 6'd30, 64'h2, 1'b0);
    send_entry(6'd2, 6'd20, 64'h4, 1'b0);
    send_entry(6'd3, 6'd10, 64'h8, 1'b0);
    send_entry(6'd4, 6'd0, 64'h10, 1'b1);
    // all in one column, repeated row
    send_entry(6'd9, 6'd17, 64'hDEAD_0001, 1'b0);
    send_entry(6'd3, 6'd17, 64'hDEAD_0002, 1'b0);
    send_entry(6'd60, 6'd17, 64'hDEAD_0003, 1'b0);
    send_entry(6'd3, 6'd17, 64'hDEAD_0004, 1'b1);

    // store exactly full, one over with the last dropped, then well over
    k = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (k)
        0:       size = DEF_MAX_ENTRIES;
        1:       size = DEF_MAX_ENTRIES + 1;
        2:       size = DEF_MAX_ENTRIES + 6;
        default: size = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72)
                                                    : $urandom_range(1, 20);
      endcase
      if (size > RANDOM_ITEMS - random_sent) size = RANDOM_ITEMS - random_sent;
      send_matrix(size);
      k++;
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);

    $display("%0d entries in %0d matrices (%0d overflowed), %0d transposed beats checked",
             items_in, sb.matrices, sb.overflow_runs, sb.beats_checked);
    $display("receiver hold-off of %0d cycles %0s", HOLDOFF_CYCLES,
             holdoff_done ? "exercised" : "not reached");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/smt_pkg.sv
hdl/smt_cell.sv
hdl/sparse_matrix_transpose.sv
hdl/smt_checker.sv
tb/tb.sv
